>>> rtl/core/ufd_pkg.sv
// ----------------------------------------------------------------------------
// ufd_pkg
// Types, codes and the CRC-16 byte update shared by the frame deframer.
// ----------------------------------------------------------------------------
package ufd_pkg;

   localparam logic [7:0]  START_SYMBOL_RESET = 8'hA5;
   localparam logic [15:0] CRC_POLY           = 16'h1021;
   localparam logic [15:0] HDR_BYTES          = 16'd6;

   // item kinds
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // frame status codes
   localparam logic [1:0] STAT_GOOD    = 2'd0;
   localparam logic [1:0] STAT_CRC_ERR = 2'd1;
   localparam logic [1:0] STAT_LEN_ERR = 2'd2;

   // frame positions
   localparam logic [1:0] POS_MIDDLE = 2'd0;
   localparam logic [1:0] POS_LAST   = 2'd1;
   localparam logic [1:0] POS_FIRST  = 2'd2;
   localparam logic [1:0] POS_ONLY   = 2'd3;

   typedef enum logic [2:0] {
      PH_HUNT   = 3'd0,
      PH_CTRL   = 3'd1,
      PH_LEN_LO = 3'd2,
      PH_LEN_HI = 3'd3,
      PH_DATA   = 3'd4,
      PH_CRC_LO = 3'd5,
      PH_CRC_HI = 3'd6
   } phase_type;

   typedef struct packed {
      logic        item_kind;
      logic [7:0]  payload_byte;
      logic [1:0]  frame_status;
      logic [1:0]  frame_position;
      logic [1:0]  device_id;
      logic [3:0]  continuity_index;
      logic [15:0] data_length;
      logic [15:0] received_crc;
      logic [15:0] computed_crc;
      logic [7:0]  packet_type;
      logic [15:0] packet_command;
      logic [15:0] packet_length;
   } rsp_item_type;

   // XMODEM CRC-16, MSB first, one byte
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> rtl/core/ufd_ifs.sv
// ----------------------------------------------------------------------------
// ufd interfaces
// Valid/ready channels for received bytes, result items and the CSR write.
// ----------------------------------------------------------------------------
interface ufd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ufd_rsp_if import ufd_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_item_type item;
   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

interface ufd_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/ufd_parser.sv
// ----------------------------------------------------------------------------
// ufd_parser
// Frame state machine with running CRC; forms a result for each payload byte and a status result at each frame end.
// ----------------------------------------------------------------------------
module ufd_parser import ufd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic [7:0]   rx_byte,
   input  logic [7:0]   start_symbol,
   output logic         has_result,
   output rsp_item_type result
);

   phase_type   phase_ff, phase_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] dlen_ff, dlen_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  ctrl_ff, ctrl_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;
   logic [7:0]  ptype_ff, ptype_in;
   logic [15:0] pcmd_ff, pcmd_in;
   logic [15:0] plen_ff, plen_in;

   logic [15:0] crc_next;
   logic [15:0] count_inc;
   logic [15:0] rx_crc;
   logic [1:0]  pos;
   logic        hdr_frame;
   logic [1:0]  pad;
   logic [17:0] len_sum;
   logic [1:0]  status;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         crc_ff    <= '0;
         dlen_ff   <= '0;
         count_ff  <= '0;
         ctrl_ff   <= '0;
         crc_lo_ff <= '0;
         ptype_ff  <= '0;
         pcmd_ff   <= '0;
         plen_ff   <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         crc_ff    <= crc_in;
         dlen_ff   <= dlen_in;
         count_ff  <= count_in;
         ctrl_ff   <= ctrl_in;
         crc_lo_ff <= crc_lo_in;
         ptype_ff  <= ptype_in;
         pcmd_ff   <= pcmd_in;
         plen_ff   <= plen_in;
      end
   end

   assign crc_next  = crc_byte(crc_ff, rx_byte);
   assign count_inc = count_ff + 16'd1;
   assign rx_crc    = {rx_byte, crc_lo_ff};
   assign pos       = ctrl_ff[3:2];
   assign hdr_frame = (pos == POS_ONLY) || (pos == POS_FIRST);
   assign pad       = 2'(3'd4 - {1'b0, plen_ff[1:0]});
   assign len_sum   = 18'(HDR_BYTES) + {2'b00, plen_ff} + {16'd0, pad};

   always_comb begin
      if (rx_crc != crc_ff) begin
         status = STAT_CRC_ERR;
      end else if (pos == POS_ONLY) begin
         if ((dlen_ff >= HDR_BYTES) && (plen_ff == 16'd0)) begin
            status = STAT_GOOD;
         end else if ((dlen_ff > HDR_BYTES) && (len_sum == {2'b00, dlen_ff})) begin
            status = STAT_GOOD;
         end else begin
            status = STAT_LEN_ERR;
         end
      end else begin
         status = STAT_GOOD;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      crc_in     = crc_ff;
      dlen_in    = dlen_ff;
      count_in   = count_ff;
      ctrl_in    = ctrl_ff;
      crc_lo_in  = crc_lo_ff;
      ptype_in   = ptype_ff;
      pcmd_in    = pcmd_ff;
      plen_in    = plen_ff;
      has_result = 1'b0;
      result     = '0;
      case (phase_ff)
         PH_CTRL: begin
            ctrl_in  = rx_byte;
            crc_in   = crc_next;
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            dlen_in  = {8'h00, rx_byte};
            crc_in   = crc_next;
            phase_in = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            dlen_in  = {rx_byte, dlen_ff[7:0]};
            crc_in   = crc_next;
            count_in = '0;
            phase_in = ({rx_byte, dlen_ff[7:0]} == 16'd0) ? PH_CRC_LO : PH_DATA;
         end
         PH_DATA: begin
            crc_in = crc_next;
            // capture the packet header from the first payload bytes
            case (count_ff)
               16'd0:   ptype_in = rx_byte;
               16'd1:   pcmd_in  = {pcmd_ff[15:8], rx_byte};
               16'd2:   pcmd_in  = {rx_byte, pcmd_ff[7:0]};
               16'd4:   plen_in  = {plen_ff[15:8], rx_byte};
               16'd5:   plen_in  = {rx_byte, plen_ff[7:0]};
               default: ;
            endcase
            count_in = count_inc;
            if (count_inc == dlen_ff) begin
               phase_in = PH_CRC_LO;
            end
            has_result          = 1'b1;
            result.item_kind    = KIND_DATA;
            result.payload_byte = rx_byte;
         end
         PH_CRC_LO: begin
            crc_lo_in = rx_byte;
            phase_in  = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            has_result              = 1'b1;
            result.item_kind        = KIND_STATUS;
            result.frame_status     = status;
            result.frame_position   = pos;
            result.device_id        = ctrl_ff[1:0];
            result.continuity_index = ctrl_ff[7:4];
            result.data_length      = dlen_ff;
            result.received_crc     = rx_crc;
            result.computed_crc     = crc_ff;
            if (hdr_frame) begin
               result.packet_type    = ptype_ff;
               result.packet_command = pcmd_ff;
               result.packet_length  = plen_ff;
            end
            phase_in = PH_HUNT;
         end
         default: begin
            // hunt; unused phase codes land here too
            phase_in = PH_HUNT;
            if (rx_byte == start_symbol) begin
               crc_in    = crc_byte(16'h0000, rx_byte);
               dlen_in   = '0;
               count_in  = '0;
               ctrl_in   = '0;
               crc_lo_in = '0;
               ptype_in  = '0;
               pcmd_in   = '0;
               plen_in   = '0;
               phase_in  = PH_CTRL;
            end
         end
      endcase
   end

endmodule

>>> rtl/core/uart_frame_deframer_crc16.sv
// A result item is registered into the output register, or into the skid while the output register is held.
// Throughput: one byte per cycle while req is ready; the CRC update and parse step are done as each byte transfers.
// A two-entry output stage (result register plus skid) keeps req ready while
// one result waits on rsp; req stalls only when both entries are full.
// Reset (synchronous, active high): parser hunts for the start symbol,
// output stage empties, start symbol returns to 0xA5.
// ----------------------------------------------------------------------------
// uart_frame_deframer_crc16
// Byte-serial frame deframer with XMODEM CRC-16 check and packet header decode.
// ----------------------------------------------------------------------------
module uart_frame_deframer_crc16 import ufd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ufd_req_if.sink     req,
   ufd_rsp_if.source   rsp,
   ufd_csr_if.sink     csr
);

   logic [7:0]   start_symbol_ff;
   logic         accept;
   logic         has_result;
   rsp_item_type result;
   logic         push;
   logic         pop;

   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   logic         skid_valid_ff;
   rsp_item_type skid_item_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_symbol_ff <= START_SYMBOL_RESET;
      end else if (csr.valid) begin
         start_symbol_ff <= csr.data;
      end
   end

   assign req.ready = !skid_valid_ff;
   assign accept    = req.valid && req.ready;

   ufd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .rx_byte      (req.rx_byte),
      .start_symbol (start_symbol_ff),
      .has_result   (has_result),
      .result       (result)
   );

   assign push = accept && has_result;
   assign pop  = out_valid_ff && rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // req is stalled; drain skid into the output register
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push && out_valid_ff && !pop) begin
         skid_valid_ff <= 1'b1;
      end else if (push) begin
         out_valid_ff <= 1'b1;
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_item_ff <= skid_item_ff;
         end
      end else if (push && out_valid_ff && !pop) begin
         skid_item_ff <= result;
      end else if (push) begin
         out_item_ff <= result;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.item  = out_item_ff;

endmodule

>>> rtl/core/ufd_checker.sv
// ----------------------------------------------------------------------------
// ufd_checker
// Port-level checks on the deframer's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ufd_checker import ufd_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_item_type rsp_item
);

   // hold a pending transfer until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.item_kind == KIND_DATA) |->
         (rsp_item.frame_status == STAT_GOOD) && (rsp_item.data_length == 16'd0) &&
         (rsp_item.computed_crc == 16'd0) && (rsp_item.received_crc == 16'd0))
      else $error("payload transfer carries status fields");

   a_crc_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.item_kind == KIND_STATUS) |->
         ((rsp_item.frame_status == STAT_CRC_ERR) ==
          (rsp_item.received_crc != rsp_item.computed_crc)))
      else $error("CRC status disagrees with CRC fields");

   a_len_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.item_kind == KIND_STATUS) &&
      (rsp_item.frame_status == STAT_LEN_ERR) |-> (rsp_item.frame_position == POS_ONLY))
      else $error("length error on a frame that is not an only frame");

endmodule

bind uart_frame_deframer_crc16 ufd_checker u_ufd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_item  (rsp.item)
);

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the byte-serial frame deframer. An opening script of frames
// with typed results is followed by random frames, noise, cut frames and bad
// CRCs under several start symbols.
// Every result transfer is checked field by field against a byte-level model
// of the parser.
// ----------------------------------------------------------------------------
module tb;
   import ufd_pkg::*;

   typedef enum {SRC_LIT, SRC_CRC_LO, SRC_CRC_HI, SRC_CRC_LO_BAD, SRC_CRC_HI_BAD} byte_src_type;
   typedef enum {TYP_PRED, TYP_PAYLOAD, TYP_GOOD, TYP_CRC_ERR, TYP_LEN_ERR} row_check_type;
   typedef enum {FAULT_NONE, FAULT_LO, FAULT_HI, FAULT_CUT} crc_fault_type;

   typedef struct {
      byte_src_type  src;
      logic [7:0]    value;
      row_check_type typed;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ufd_req_if req_ch ();
   ufd_rsp_if rsp_ch ();
   ufd_csr_if csr_ch ();

   uart_frame_deframer_crc16 dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   always #6 clock = ~clock;

   // parser model state
   phase_type   parse_ph;
   logic [15:0] crc_run;
   logic [15:0] frame_len;
   logic [15:0] byte_count;
   logic [7:0]  ctrl_byte;
   logic [7:0]  crc_lo_byte;
   logic [39:0] pkt_hdr;
   logic [7:0]  start_sym;

   rsp_item_type  deframed_q[$];
   int            mismatch_count = 0;
   int            bytes_sent = 0;
   logic          calm = 1'b0;
   row_check_type cur_typed = TYP_PRED;

   string field_names [12] = '{"item_kind", "payload_byte", "frame_status",
      "frame_position", "device_id", "continuity_index", "data_length",
      "received_crc", "computed_crc", "packet_type", "packet_command",
      "packet_length"};

   script_row_type opening_rows [27] = '{
      '{SRC_LIT, 8'h00, TYP_PRED},
      '{SRC_LIT, 8'hFF, TYP_PRED},
      // only frame with zero length: too short for a packet header
      '{SRC_LIT, START_SYMBOL_RESET, TYP_PRED},
      '{SRC_LIT, 8'hFF, TYP_PRED},
      '{SRC_LIT, 8'h00, TYP_PRED},
      '{SRC_LIT, 8'h00, TYP_PRED},
      '{SRC_CRC_LO, 8'h00, TYP_PRED},
      '{SRC_CRC_HI, 8'h00, TYP_LEN_ERR},
      // middle frame, one byte, corrupted CRC
      '{SRC_LIT, START_SYMBOL_RESET, TYP_PRED},
      '{SRC_LIT, 8'h00, TYP_PRED},
      '{SRC_LIT, 8'h01, TYP_PRED},
      '{SRC_LIT, 8'h00, TYP_PRED},
      '{SRC_LIT, 8'hFF, TYP_PAYLOAD},
      '{SRC_CRC_LO_BAD, 8'h00, TYP_PRED},
      '{SRC_CRC_HI, 8'h00, TYP_CRC_ERR},
      // only frame, six bytes, packet length zero
      '{SRC_LIT, START_SYMBOL_RESET, TYP_PRED},
      '{SRC_LIT, 8'h0C, TYP_PRED},
      '{SRC_LIT, 8'h06, TYP_PRED},
      '{SRC_LIT, 8'h00, TYP_PRED},
      '{SRC_LIT, 8'h01, TYP_PAYLOAD},
      '{SRC_LIT, 8'h34, TYP_PAYLOAD},
      '{SRC_LIT, 8'h12, TYP_PAYLOAD},
      '{SRC_LIT, 8'h00, TYP_PAYLOAD},
      '{SRC_LIT, 8'h00, TYP_PAYLOAD},
      '{SRC_LIT, 8'h00, TYP_PAYLOAD},
      '{SRC_CRC_LO, 8'h00, TYP_PRED},
      '{SRC_CRC_HI, 8'h00, TYP_GOOD}
   };

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = r[15] ^ b[i];
         r  = {r[14:0], 1'b0};
         if (fb) begin
            r = r ^ CRC_POLY;
         end
      end
      return r;
   endfunction

   task automatic deframe_byte(input logic [7:0] b);
      rsp_item_type it;
      logic [15:0]  rx_crc;
      logic [1:0]   pos;
      int           plen;
      int           pad;
      int           dl;
      it = '0;
      case (parse_ph)
         PH_CTRL: begin
            ctrl_byte = b;
            crc_run   = crc_step(crc_run, b);
            parse_ph  = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            frame_len = {8'h00, b};
            crc_run   = crc_step(crc_run, b);
            parse_ph  = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            frame_len[15:8] = b;
            crc_run    = crc_step(crc_run, b);
            byte_count = 16'd0;
            parse_ph   = (frame_len == 16'd0) ? PH_CRC_LO : PH_DATA;
         end
         PH_DATA: begin
            crc_run = crc_step(crc_run, b);
            // byte 3 is reserved and not kept
            case (byte_count)
               16'd0: pkt_hdr[7:0]   = b;
               16'd1: pkt_hdr[15:8]  = b;
               16'd2: pkt_hdr[23:16] = b;
               16'd4: pkt_hdr[31:24] = b;
               16'd5: pkt_hdr[39:32] = b;
               default: ;
            endcase
            byte_count = byte_count + 16'd1;
            if (byte_count == frame_len) begin
               parse_ph = PH_CRC_LO;
            end
            it.item_kind    = KIND_DATA;
            it.payload_byte = b;
            deframed_q.push_back(it);
         end
         PH_CRC_LO: begin
            crc_lo_byte = b;
            parse_ph    = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            rx_crc = {b, crc_lo_byte};
            pos    = ctrl_byte[3:2];
            if (pos == POS_ONLY || pos == POS_FIRST) begin
               it.packet_type    = pkt_hdr[7:0];
               it.packet_command = pkt_hdr[23:8];
               it.packet_length  = pkt_hdr[39:24];
            end
            plen = int'(it.packet_length);
            pad  = (4 - (plen % 4)) % 4;
            dl   = int'(frame_len);
            if (rx_crc != crc_run) begin
               it.frame_status = STAT_CRC_ERR;
            end else if (pos != POS_ONLY) begin
               it.frame_status = STAT_GOOD;
            end else if (dl >= int'(HDR_BYTES) && plen == 0) begin
               it.frame_status = STAT_GOOD;
            end else if (dl > int'(HDR_BYTES) && int'(HDR_BYTES) + plen + pad == dl) begin
               it.frame_status = STAT_GOOD;
            end else begin
               it.frame_status = STAT_LEN_ERR;
            end
            it.item_kind        = KIND_STATUS;
            it.frame_position   = pos;
            it.device_id        = ctrl_byte[1:0];
            it.continuity_index = ctrl_byte[7:4];
            it.data_length      = frame_len;
            it.received_crc     = rx_crc;
            it.computed_crc     = crc_run;
            deframed_q.push_back(it);
            parse_ph = PH_HUNT;
         end
         default: begin
            parse_ph = PH_HUNT;
            if (b == start_sym) begin
               crc_run     = crc_step(16'h0000, b);
               frame_len   = 16'd0;
               byte_count  = 16'd0;
               ctrl_byte   = 8'h00;
               crc_lo_byte = 8'h00;
               pkt_hdr     = '0;
               parse_ph    = PH_CTRL;
            end
         end
      endcase
   endtask

   task automatic flag_mismatch(input string msg);
      if (mismatch_count < 50) begin
         $display("%0t mismatch: %s", $realtime, msg);
      end
      mismatch_count++;
   endtask

   function automatic void split_fields(input rsp_item_type it, output logic [15:0] v [12]);
      v[0]  = 16'(it.item_kind);
      v[1]  = 16'(it.payload_byte);
      v[2]  = 16'(it.frame_status);
      v[3]  = 16'(it.frame_position);
      v[4]  = 16'(it.device_id);
      v[5]  = 16'(it.continuity_index);
      v[6]  = it.data_length;
      v[7]  = it.received_crc;
      v[8]  = it.computed_crc;
      v[9]  = 16'(it.packet_type);
      v[10] = it.packet_command;
      v[11] = it.packet_length;
   endfunction

   task automatic compare_item(input rsp_item_type got, input rsp_item_type want);
      logic [15:0] g [12];
      logic [15:0] w [12];
      split_fields(got, g);
      split_fields(want, w);
      for (int i = 0; i < 12; i++) begin
         if (g[i] !== w[i]) begin
            flag_mismatch($sformatf("%s got %h want %h", field_names[i], g[i], w[i]));
         end
      end
   endtask

   // one process samples every channel, so the order of pops and pushes is fixed
   always @(posedge clock) begin
      rsp_item_type want;
      int           n;
      if (reset) begin
         parse_ph    = PH_HUNT;
         crc_run     = 16'h0000;
         frame_len   = 16'd0;
         byte_count  = 16'd0;
         ctrl_byte   = 8'h00;
         crc_lo_byte = 8'h00;
         pkt_hdr     = '0;
         start_sym   = START_SYMBOL_RESET;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (deframed_q.size() == 0) begin
               flag_mismatch($sformatf("unexpected item %h", rsp_ch.item));
            end else begin
               want = deframed_q.pop_front();
               compare_item(rsp_ch.item, want);
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            start_sym = csr_ch.data;
         end
         if (req_ch.valid && req_ch.ready) begin
            n = deframed_q.size();
            deframe_byte(req_ch.rx_byte);
            if (cur_typed != TYP_PRED) begin
               if (deframed_q.size() == n) begin
                  deframed_q.push_back('0);
               end
               want = deframed_q[deframed_q.size() - 1];
               case (cur_typed)
                  TYP_PAYLOAD: begin
                     want              = '0;
                     want.item_kind    = KIND_DATA;
                     want.payload_byte = req_ch.rx_byte;
                  end
                  TYP_GOOD:    want.frame_status = STAT_GOOD;
                  TYP_CRC_ERR: want.frame_status = STAT_CRC_ERR;
                  default:     want.frame_status = STAT_LEN_ERR;
               endcase
               if (cur_typed != TYP_PAYLOAD) begin
                  want.item_kind = KIND_STATUS;
               end
               deframed_q[deframed_q.size() - 1] = want;
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_ch.ready = calm || ($urandom_range(99) >= 11);
   end

   // call at a falling edge; returns at the falling edge after the transfer
   task automatic put_byte(input byte_src_type src, input logic [7:0] v,
                           input row_check_type t);
      logic [7:0] b;
      while (!calm && $urandom_range(99) < 11) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      case (src)
         SRC_CRC_LO:     b = crc_run[7:0];
         SRC_CRC_HI:     b = crc_run[15:8];
         SRC_CRC_LO_BAD: b = ~crc_run[7:0];
         SRC_CRC_HI_BAD: b = ~crc_run[15:8];
         default:        b = v;
      endcase
      req_ch.valid   = 1'b1;
      req_ch.rx_byte = b;
      cur_typed      = t;
      bytes_sent++;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [7:0] ctrl, input int dl, input logic [47:0] hdr,
                             input int keep, input crc_fault_type fault);
      int         count;
      logic [7:0] b;
      count = (fault == FAULT_CUT) ? keep : dl;
      put_byte(SRC_LIT, start_sym, TYP_PRED);
      put_byte(SRC_LIT, ctrl, TYP_PRED);
      put_byte(SRC_LIT, 8'(dl), TYP_PRED);
      put_byte(SRC_LIT, 8'(dl >> 8), TYP_PRED);
      for (int i = 0; i < count; i++) begin
         if (i < 6) begin
            b = hdr[8*i +: 8];
         end else begin
            b = 8'($urandom);
         end
         put_byte(SRC_LIT, b, TYP_PRED);
      end
      if (fault != FAULT_CUT) begin
         put_byte((fault == FAULT_LO) ? SRC_CRC_LO_BAD : SRC_CRC_LO, 8'h00, TYP_PRED);
         put_byte((fault == FAULT_HI) ? SRC_CRC_HI_BAD : SRC_CRC_HI, 8'h00, TYP_PRED);
      end
   endtask

   function automatic int pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 70) begin
         return $urandom_range(0, 16);
      end else if (r < 95) begin
         return $urandom_range(17, 64);
      end
      return $urandom_range(65, 300);
   endfunction

   task automatic random_sequence();
      int            r;
      int            dl;
      int            keep;
      int            plen;
      int            pad;
      logic [7:0]    ctrl;
      logic [7:0]    b;
      logic [1:0]    pos;
      logic [47:0]   hdr;
      crc_fault_type fault;
      r = $urandom_range(99);
      if (r < 10) begin
         // line noise while hunting
         repeat ($urandom_range(1, 4)) begin
            b = 8'($urandom);
            if (b == start_sym) begin
               b = ~b;
            end
            put_byte(SRC_LIT, b, TYP_PRED);
         end
      end else begin
         ctrl = 8'($urandom);
         pos  = ctrl[3:2];
         plen = $urandom_range(0, 40);
         pad  = (4 - (plen % 4)) % 4;
         keep = 0;
         if (pos == POS_ONLY || pos == POS_FIRST) begin
            case ($urandom_range(9))
               0, 1, 2, 3, 4: dl = 6 + plen + pad;
               5: begin
                  plen = 0;
                  dl   = $urandom_range(6, 30);
               end
               6: dl = 6 + plen + pad + ($urandom_range(1) ? 1 : -1);
               7: dl = $urandom_range(0, 5);
               8: begin
                  plen = int'(16'($urandom));
                  dl   = $urandom_range(6, 40);
               end
               default: dl = pick_length();
            endcase
         end else begin
            dl = pick_length();
         end
         hdr = {16'(plen), 8'($urandom), 16'($urandom), 8'($urandom)};
         if (r < 20) begin
            // cut short: the next bytes fall into the payload
            fault = FAULT_CUT;
            dl    = $urandom_range(1, 16);
            keep  = $urandom_range(0, dl - 1);
         end else if (r < 28) begin
            fault = $urandom_range(1) ? FAULT_LO : FAULT_HI;
         end else begin
            fault = FAULT_NONE;
         end
         send_frame(ctrl, dl, hdr, keep, fault);
      end
   endtask

   task automatic run_phase(input int n);
      int target;
      target = bytes_sent + n;
      while (bytes_sent < target) begin
         random_sequence();
      end
   endtask

   task automatic drain();
      req_ch.valid = 1'b0;
      while (deframed_q.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic set_start_symbol(input logic [7:0] v);
      drain();
      // a frame may still be in the parser without a result pending
      repeat (4) @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.data  = v;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = 8'h00;
      csr_ch.valid   = 1'b0;
      csr_ch.data    = 8'h00;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (opening_rows[i]) begin
         put_byte(opening_rows[i].src, opening_rows[i].value, opening_rows[i].typed);
      end
      run_phase(300);

      set_start_symbol(8'h00);
      calm = 1'b1;
      run_phase(150);
      calm = 1'b0;

      set_start_symbol(8'hFF);
      run_phase(150);

      set_start_symbol(8'($urandom));
      run_phase(200);

      set_start_symbol(START_SYMBOL_RESET);
      run_phase(50);

      drain();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && deframed_q.size() == 0) begin
         $display("uart_frame_deframer_crc16 test passed");
      end else begin
         $display("uart_frame_deframer_crc16 test failed");
      end
      $finish;
   end

   initial begin
      #6_000_000;
      $display("uart_frame_deframer_crc16 test failed");
      $finish;
   end

endmodule

>>> files.f
rtl/core/ufd_pkg.sv
rtl/core/ufd_ifs.sv
rtl/core/ufd_parser.sv
rtl/core/uart_frame_deframer_crc16.sv
rtl/core/ufd_checker.sv
bench/tb.sv
